>>> hdl/chg_pkg.sv
// shared constants, types and state codes for the gift-wrapping hull block
`timescale 1ns / 1ps

package chg_pkg;

    localparam int MAX_POINTS = 64;
    localparam int COORD_BITS = 16;
    localparam int SMALL_SET  = 3;

    localparam int IDX_W  = $clog2(MAX_POINTS);
    localparam int CNT_W  = IDX_W + 1;
    localparam int DIFF_W = COORD_BITS + 1;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int WIDE_W = PROD_W + 1;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [DIFF_W-1:0]     t_diff;
    typedef logic signed [PROD_W-1:0]     t_prod;
    typedef logic signed [WIDE_W-1:0]     t_wide;
    typedef logic [IDX_W-1:0]             t_idx;
    typedef logic [CNT_W-1:0]             t_cnt;

    typedef struct packed {
        t_coord px;
        t_coord py;
        logic   set_end;
    } t_in_item;

    typedef struct packed {
        t_coord hx;
        t_coord hy;
        logic   hull_end;
        logic   overflow;
    } t_out_item;

    // controls for the compare datapath
    typedef struct packed {
        logic diff_en;
        logic mul_en;
        logic cmp_en;
        logic first;
    } t_cmp_ctl;

    typedef enum logic [3:0] {
        S_LOAD,
        S_START,
        S_LEFT,
        S_PUSH,
        S_RD,
        S_DIFF,
        S_MUL,
        S_CMP,
        S_STEP,
        S_E_ORD,
        S_E_PT,
        S_E_OUT,
        S_E_WAIT
    } t_state;

endpackage

>>> hdl/chg_cmp.sv
// candidate compare datapath: differences, products, cross and distance test
`timescale 1ns / 1ps

module chg_cmp (
    input  logic              i_clk,
    input  chg_pkg::t_cmp_ctl i_ctl,
    input  chg_pkg::t_coord   i_px,
    input  chg_pkg::t_coord   i_py,
    input  chg_pkg::t_coord   i_cx,
    input  chg_pkg::t_coord   i_cy,
    output logic              o_take,
    output chg_pkg::t_diff    o_bx,
    output chg_pkg::t_diff    o_by
);
    import chg_pkg::*;

    t_diff r_dx, r_dy;
    t_diff r_bx, r_by;
    t_prod r_p1, r_p2, r_q1, r_q2;
    t_wide r_nd;
    t_wide s_cp, s_dist;

    // point minus current vertex
    always_ff @(posedge i_clk) begin
        if (i_ctl.diff_en) begin
            r_dx <= t_diff'(i_px) - t_diff'(i_cx);
            r_dy <= t_diff'(i_py) - t_diff'(i_cy);
        end
    end

    // cross product terms and squared distance terms
    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_p1 <= r_bx * r_dy;
            r_p2 <= r_by * r_dx;
            r_q1 <= r_dx * r_dx;
            r_q2 <= r_dy * r_dy;
        end
    end

    // turn test, collinear ties go to the farther point
    always_comb begin
        s_cp   = t_wide'(r_p1) - t_wide'(r_p2);
        s_dist = t_wide'(r_q1) + t_wide'(r_q2);
        o_take = i_ctl.first || (s_cp > 0) || ((s_cp == 0) && (s_dist > r_nd));
    end

    // candidate offset and its distance
    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp_en && o_take) begin
            r_bx <= r_dx;
            r_by <= r_dy;
            r_nd <= s_dist;
        end
    end

    assign o_bx = r_bx;
    assign o_by = r_by;

endmodule

>>> hdl/convex_hull_gift_wrap.sv
// Loading: one point item per cycle, stall low only while loading.
// Walk: leftmost search scans all points; each hull vertex compares every
// other point in read, diff, mul, cmp states. Output: each vertex item
// passes order, point, output and wait states, holding in wait on a
// stall; sets of 3 or fewer points are echoed. Synchronous active-low reset
// empties the set and returns to loading; memory contents are not cleared.
`timescale 1ns / 1ps

module convex_hull_gift_wrap (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  chg_pkg::t_in_item i_in_item,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output chg_pkg::t_out_item o_out_item
);
    import chg_pkg::*;

    t_state    r_state, n_state;
    t_cnt      r_count, r_n, r_idx, r_cnt, r_k;
    logic      r_dropped, r_lv, r_have, r_ovf, r_small, r_out_vld;
    t_idx      r_lidx, r_start, r_cur_idx, r_nidx;
    t_coord    r_bestx, r_besty, r_curx, r_cury;
    t_out_item r_out;

    logic [2*COORD_BITS-1:0] r_store [MAX_POINTS];
    logic [2*COORD_BITS-1:0] r_st_q;
    t_idx                    r_order [MAX_POINTS];
    t_idx                    r_ord_q;

    t_idx     s_rd_addr;
    t_cmp_ctl s_ctl;
    logic     s_in_acc, s_out_acc, s_store_wr, s_last, s_take, s_left_done;
    t_coord   s_qx, s_qy;
    t_diff    s_bx, s_by;

    assign s_in_acc    = i_in_valid && !o_in_stall;
    assign s_out_acc   = r_out_vld && !i_out_stall;
    assign s_store_wr  = s_in_acc && (r_count < t_cnt'(MAX_POINTS));
    assign s_last      = ((r_k + t_cnt'(1)) == r_cnt);
    assign s_left_done = (r_idx == r_n) && !r_lv;
    assign s_qx        = t_coord'(r_st_q[2*COORD_BITS-1:COORD_BITS]);
    assign s_qy        = t_coord'(r_st_q[COORD_BITS-1:0]);

    // point memory
    always_ff @(posedge i_clk) begin
        if (s_store_wr) begin
            r_store[r_count[IDX_W-1:0]] <= {i_in_item.px, i_in_item.py};
        end
        r_st_q <= r_store[s_rd_addr];
    end

    // hull order memory
    always_ff @(posedge i_clk) begin
        if ((r_state == S_PUSH) && (r_cnt != t_cnt'(MAX_POINTS))) begin
            r_order[r_cnt[IDX_W-1:0]] <= r_cur_idx;
        end
        r_ord_q <= r_order[r_k[IDX_W-1:0]];
    end

    // compare datapath
    chg_cmp u_cmp (
        .i_clk  (i_clk),
        .i_ctl  (s_ctl),
        .i_px   (s_qx),
        .i_py   (s_qy),
        .i_cx   (r_curx),
        .i_cy   (r_cury),
        .o_take (s_take),
        .o_bx   (s_bx),
        .o_by   (s_by)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_LOAD: begin
                if (s_in_acc && i_in_item.set_end) n_state = S_START;
            end
            S_START: begin
                n_state = (r_count <= t_cnt'(SMALL_SET)) ? S_E_ORD : S_LEFT;
            end
            S_LEFT: begin
                if (s_left_done) n_state = S_PUSH;
            end
            S_PUSH: begin
                n_state = (r_cnt == t_cnt'(MAX_POINTS)) ? S_E_ORD : S_RD;
            end
            S_RD: begin
                if (r_idx == r_n) begin
                    n_state = S_STEP;
                end else if (r_idx[IDX_W-1:0] != r_cur_idx) begin
                    n_state = S_DIFF;
                end
            end
            S_DIFF:  n_state = S_MUL;
            S_MUL:   n_state = S_CMP;
            S_CMP:   n_state = S_RD;
            S_STEP: begin
                n_state = (r_nidx == r_start) ? S_E_ORD : S_PUSH;
            end
            S_E_ORD: n_state = S_E_PT;
            S_E_PT:  n_state = S_E_OUT;
            S_E_OUT: n_state = S_E_WAIT;
            S_E_WAIT: begin
                if (s_out_acc) n_state = s_last ? S_LOAD : S_E_ORD;
            end
            default: n_state = S_LOAD;
        endcase
    end

    // state outputs
    always_comb begin
        o_in_stall    = 1'b1;
        s_rd_addr     = r_idx[IDX_W-1:0];
        s_ctl.diff_en = 1'b0;
        s_ctl.mul_en  = 1'b0;
        s_ctl.cmp_en  = 1'b0;
        s_ctl.first   = !r_have;
        case (r_state)
            S_LOAD:  o_in_stall = 1'b0;
            S_E_PT:  s_rd_addr = r_small ? r_k[IDX_W-1:0] : r_ord_q;
            S_DIFF:  s_ctl.diff_en = 1'b1;
            S_MUL:   s_ctl.mul_en = 1'b1;
            S_CMP:   s_ctl.cmp_en = 1'b1;
            default: s_rd_addr = r_idx[IDX_W-1:0];
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    // walk control and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_dropped <= 1'b0;
            r_n       <= '0;
            r_idx     <= '0;
            r_cnt     <= '0;
            r_k       <= '0;
            r_lv      <= 1'b0;
            r_have    <= 1'b0;
            r_ovf     <= 1'b0;
            r_small   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            case (r_state)
                S_LOAD: begin
                    if (s_store_wr) begin
                        r_count <= r_count + t_cnt'(1);
                    end else if (s_in_acc) begin
                        r_dropped <= 1'b1;
                    end
                end
                S_START: begin
                    r_n     <= r_count;
                    r_cnt   <= r_count;
                    r_ovf   <= r_dropped;
                    r_small <= (r_count <= t_cnt'(SMALL_SET));
                    r_idx   <= '0;
                    r_lv    <= 1'b0;
                    r_k     <= '0;
                end
                S_LEFT: begin
                    r_lv   <= (r_idx != r_n);
                    r_lidx <= r_idx[IDX_W-1:0];
                    if (r_idx != r_n) r_idx <= r_idx + t_cnt'(1);
                    if (r_lv && ((r_lidx == '0) || (s_qx < r_bestx) ||
                                 ((s_qx == r_bestx) && (s_qy < r_besty)))) begin
                        r_bestx <= s_qx;
                        r_besty <= s_qy;
                        r_start <= r_lidx;
                    end
                    if (s_left_done) begin
                        r_curx    <= r_bestx;
                        r_cury    <= r_besty;
                        r_cur_idx <= r_start;
                        r_cnt     <= '0;
                    end
                end
                S_PUSH: begin
                    if (r_cnt == t_cnt'(MAX_POINTS)) begin
                        r_ovf <= 1'b1;
                        r_k   <= '0;
                    end else begin
                        r_cnt  <= r_cnt + t_cnt'(1);
                        r_idx  <= '0;
                        r_have <= 1'b0;
                    end
                end
                S_RD: begin
                    if ((r_idx != r_n) && (r_idx[IDX_W-1:0] == r_cur_idx)) begin
                        r_idx <= r_idx + t_cnt'(1);
                    end
                end
                S_CMP: begin
                    if (s_take) begin
                        r_nidx <= r_idx[IDX_W-1:0];
                        r_have <= 1'b1;
                    end
                    r_idx <= r_idx + t_cnt'(1);
                end
                S_STEP: begin
                    r_curx    <= r_curx + s_bx[COORD_BITS-1:0];
                    r_cury    <= r_cury + s_by[COORD_BITS-1:0];
                    r_cur_idx <= r_nidx;
                    r_k       <= '0;
                end
                S_E_OUT: begin
                    r_out.hx       <= s_qx;
                    r_out.hy       <= s_qy;
                    r_out.hull_end <= s_last;
                    r_out.overflow <= r_ovf;
                    r_out_vld      <= 1'b1;
                end
                S_E_WAIT: begin
                    if (s_out_acc) begin
                        r_out_vld <= 1'b0;
                        if (s_last) begin
                            r_count   <= '0;
                            r_dropped <= 1'b0;
                        end else begin
                            r_k <= r_k + t_cnt'(1);
                        end
                    end
                end
                default: begin
                    r_out_vld <= r_out_vld;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

    // checks on the walk and output sequencing
    a_valid_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_state == S_E_WAIT))
        else $error("result valid outside the output wait");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count <= t_cnt'(MAX_POINTS)) && (r_cnt <= t_cnt'(MAX_POINTS)))
        else $error("point or vertex count beyond capacity");

    a_cur_in_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PUSH) |-> (t_cnt'(r_cur_idx) < r_n))
        else $error("current vertex outside the stored set");

    a_set_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_out_item.hull_end) |=>
            ((r_state == S_LOAD) && (r_count == '0) && !r_dropped))
        else $error("store not emptied after the final vertex");

endmodule
